FILE: rtl/lphm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear probe hash map package
// Shared widths, codes and the command/status bundles between controller
// and datapath.
// ----------------------------------------------------------------------------
package lphm_pkg;

  // Parameter defaults
  localparam int unsigned CapacityDef = 1024;
  localparam int unsigned KeyBitsDef  = 32;
  localparam int unsigned DataBitsDef = 32;

  // Fixed field widths on the ports
  localparam int unsigned KeyW   = 32;
  localparam int unsigned HashW  = 32;
  localparam int unsigned ValueW = 32;
  localparam int unsigned LimitW = 11;
  localparam int unsigned TotalW = 11;

  localparam logic [LimitW-1:0] FillLimitRst = 11'd768;

  typedef enum logic [1:0] {
    KIND_LOOKUP = 2'd0,
    KIND_INSERT = 2'd1,
    KIND_REMOVE = 2'd2,
    KIND_CLEAR  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    RES_DONE      = 2'd0,
    RES_NOT_FOUND = 2'd1,
    RES_FULL      = 2'd2
  } res_e;

  typedef enum logic [1:0] {
    SLOT_EMPTY = 2'd0,
    SLOT_LIVE  = 2'd1,
    SLOT_TOMB  = 2'd2
  } slot_e;

  typedef enum logic [1:0] {
    WR_NONE       = 2'd0,
    WR_FREE_LIVE  = 2'd1,
    WR_MATCH_LIVE = 2'd2,
    WR_MATCH_TOMB = 2'd3
  } wr_e;

  typedef enum logic [1:0] {
    CNT_HOLD = 2'd0,
    CNT_INC  = 2'd1,
    CNT_DEC  = 2'd2,
    CNT_ZERO = 2'd3
  } cnt_e;

  // Controller to datapath
  typedef struct packed {
    logic load;        // capture the accepted item
    logic issue;       // read the slot at the probe pointer and advance
    logic sweep;       // write the slot at the probe pointer empty and advance
    wr_e  wr;          // slot update after the probe
    cnt_e cnt;         // live count update
    logic res_load;    // load the output register
    res_e res_status;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic  probe_done;
    logic  sweep_last;
    logic  match;
    logic  free_found;
    logic  can_add;
    logic  out_free;
    kind_e kind;
  } sts_t;

endpackage

FILE: rtl/lphm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear probe hash map controller
// Sequences reset sweep, probe, slot update, clear sweep and result hand-off.
// ----------------------------------------------------------------------------
module lphm_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_valid_i,
  input  lphm_pkg::kind_e  s_kind_i,
  input  lphm_pkg::sts_t   sts_i,
  output logic             s_ready_o,
  output lphm_pkg::cmd_t   cmd_o
);
  import lphm_pkg::*;

  typedef enum logic [6:0] {
    S_INIT  = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_PROBE = 7'b0000100,
    S_APPLY = 7'b0001000,
    S_TOMB  = 7'b0010000,
    S_CLEAR = 7'b0100000,
    S_RESP  = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  res_e   res_q, res_d;

  always_comb begin
    state_d = state_q;
    res_d   = res_q;
    cmd_o   = '{load: 1'b0, issue: 1'b0, sweep: 1'b0, wr: WR_NONE, cnt: CNT_HOLD,
                res_load: 1'b0, res_status: res_q};
    unique case (state_q)
      S_INIT: begin
        cmd_o.sweep = 1'b1;
        if (sts_i.sweep_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (s_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = (s_kind_i == KIND_CLEAR) ? S_CLEAR : S_PROBE;
        end
      end
      S_PROBE: begin
        if (sts_i.probe_done) state_d = S_APPLY;
        else cmd_o.issue = 1'b1;
      end
      S_APPLY: begin
        state_d = S_RESP;
        unique case (sts_i.kind)
          KIND_REMOVE: begin
            if (sts_i.match) begin
              cmd_o.wr  = WR_MATCH_TOMB;
              cmd_o.cnt = CNT_DEC;
              res_d     = RES_DONE;
            end else begin
              res_d = RES_NOT_FOUND;
            end
          end
          KIND_INSERT: begin
            if (sts_i.match) begin
              res_d = RES_DONE;
              // move the pair forward to an earlier tombstone
              if (sts_i.free_found) begin
                cmd_o.wr = WR_FREE_LIVE;
                state_d  = S_TOMB;
              end else begin
                cmd_o.wr = WR_MATCH_LIVE;
              end
            end else if (sts_i.can_add && sts_i.free_found) begin
              cmd_o.wr  = WR_FREE_LIVE;
              cmd_o.cnt = CNT_INC;
              res_d     = RES_DONE;
            end else begin
              res_d = RES_FULL;
            end
          end
          default: begin
            res_d = sts_i.match ? RES_DONE : RES_NOT_FOUND;
          end
        endcase
      end
      S_TOMB: begin
        cmd_o.wr = WR_MATCH_TOMB;
        state_d  = S_RESP;
      end
      S_CLEAR: begin
        cmd_o.sweep = 1'b1;
        if (sts_i.sweep_last) begin
          cmd_o.cnt = CNT_ZERO;
          res_d     = RES_DONE;
          state_d   = S_RESP;
        end
      end
      S_RESP: begin
        if (sts_i.out_free) begin
          cmd_o.res_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_INIT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      res_q   <= RES_DONE;
    end else begin
      state_q <= state_d;
      res_q   <= res_d;
    end
  end

  assign s_ready_o = (state_q == S_IDLE);

endmodule

FILE: rtl/lphm_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear probe hash map datapath
// Slot memory, probe pointer, match/free tracking, live count, output register.
// ----------------------------------------------------------------------------
module lphm_dp #(
  parameter int unsigned CAPACITY  = lphm_pkg::CapacityDef,
  parameter int unsigned KEY_BITS  = lphm_pkg::KeyBitsDef,
  parameter int unsigned DATA_BITS = lphm_pkg::DataBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic [lphm_pkg::LimitW-1:0]   cfg_data_i,
  input  lphm_pkg::kind_e               in_kind_i,
  input  logic [lphm_pkg::KeyW-1:0]     in_key_i,
  input  logic [lphm_pkg::HashW-1:0]    in_hash_i,
  input  logic [lphm_pkg::ValueW-1:0]   in_value_i,
  input  lphm_pkg::cmd_t                cmd_i,
  input  logic                          out_ready_i,
  output lphm_pkg::sts_t                sts_o,
  output logic                          out_valid_o,
  output lphm_pkg::res_e                out_status_o,
  output logic                          out_had_o,
  output logic [lphm_pkg::KeyW-1:0]     out_key_o,
  output logic [lphm_pkg::ValueW-1:0]   out_value_o,
  output logic [lphm_pkg::TotalW-1:0]   out_total_o
);
  import lphm_pkg::*;

  localparam int unsigned IdxW  = $clog2(CAPACITY);
  localparam int unsigned CntW  = IdxW + 1;
  localparam int unsigned CmpW  = (CntW > LimitW) ? CntW : LimitW;
  localparam int unsigned EntW  = 2 + KEY_BITS + DATA_BITS;

  // entry: {status, key, data}
  logic [EntW-1:0] mem [CAPACITY];
  logic [EntW-1:0] rd_q;

  logic                 we;
  logic [IdxW-1:0]      waddr;
  logic [EntW-1:0]      wdata;

  logic                 rvalid_q;
  logic [IdxW-1:0]      pos_q, rpos_q, ecnt_q;
  kind_e                kind_q;
  logic [KEY_BITS-1:0]  key_q, old_key_q;
  logic [DATA_BITS-1:0] val_q, old_val_q;
  logic                 match_q, free_q;
  logic [IdxW-1:0]      match_idx_q, free_idx_q;
  logic [CntW-1:0]      count_q;
  logic [LimitW-1:0]    limit_q;

  logic                 out_valid_q, out_had_q;
  res_e                 out_status_q;
  logic [KeyW-1:0]      out_key_q;
  logic [ValueW-1:0]    out_val_q;
  logic [TotalW-1:0]    out_total_q;

  slot_e                rd_stat;
  logic [KEY_BITS-1:0]  rd_key;
  logic [DATA_BITS-1:0] rd_val;
  logic                 hit_empty, hit_match, hit_tomb, take_free, ecnt_last;

  assign rd_stat   = slot_e'(rd_q[EntW-1 -: 2]);
  assign rd_key    = rd_q[DATA_BITS +: KEY_BITS];
  assign rd_val    = rd_q[DATA_BITS-1:0];
  assign ecnt_last = &ecnt_q;

  assign hit_empty = rvalid_q && (rd_stat == SLOT_EMPTY);
  assign hit_match = rvalid_q && (rd_stat == SLOT_LIVE) && (rd_key == key_q);
  assign hit_tomb  = rvalid_q && (rd_stat != SLOT_EMPTY) && (rd_stat != SLOT_LIVE);
  assign take_free = (hit_empty || hit_tomb) && !free_q;

  // Slot write select
  always_comb begin
    we    = 1'b0;
    waddr = pos_q;
    wdata = {SLOT_EMPTY, {KEY_BITS{1'b0}}, {DATA_BITS{1'b0}}};
    if (cmd_i.sweep) begin
      we = 1'b1;
    end else begin
      case (cmd_i.wr)
        WR_FREE_LIVE: begin
          we    = 1'b1;
          waddr = free_idx_q;
          wdata = {SLOT_LIVE, key_q, val_q};
        end
        WR_MATCH_LIVE: begin
          we    = 1'b1;
          waddr = match_idx_q;
          wdata = {SLOT_LIVE, key_q, val_q};
        end
        WR_MATCH_TOMB: begin
          we    = 1'b1;
          waddr = match_idx_q;
          wdata = {SLOT_TOMB, old_key_q, old_val_q};
        end
        default: we = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rd_q <= mem[pos_q];
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rvalid_q    <= 1'b0;
      pos_q       <= '0;
      ecnt_q      <= '0;
      match_q     <= 1'b0;
      free_q      <= 1'b0;
      count_q     <= '0;
      limit_q     <= FillLimitRst;
      out_valid_q <= 1'b0;
    end else begin
      rvalid_q <= cmd_i.issue;
      if (cmd_i.load) begin
        pos_q   <= in_hash_i[IdxW-1:0];
        ecnt_q  <= '0;
        match_q <= 1'b0;
        free_q  <= 1'b0;
      end else begin
        if (cmd_i.issue || cmd_i.sweep) pos_q <= pos_q + 1'b1;
        if (rvalid_q || cmd_i.sweep) ecnt_q <= ecnt_q + 1'b1;
        if (hit_match) match_q <= 1'b1;
        if (take_free) free_q <= 1'b1;
      end
      case (cmd_i.cnt)
        CNT_INC:  count_q <= count_q + 1'b1;
        CNT_DEC:  count_q <= count_q - 1'b1;
        CNT_ZERO: count_q <= '0;
        default:  count_q <= count_q;
      endcase
      if (cfg_valid_i) limit_q <= cfg_data_i;
      if (cmd_i.res_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    rpos_q <= pos_q;
    if (cmd_i.load) begin
      kind_q <= in_kind_i;
      key_q  <= KEY_BITS'(in_key_i);
      val_q  <= DATA_BITS'(in_value_i);
    end
    if (hit_match) begin
      match_idx_q <= rpos_q;
      old_key_q   <= rd_key;
      old_val_q   <= rd_val;
    end
    if (take_free) free_idx_q <= rpos_q;
    if (cmd_i.res_load) begin
      out_status_q <= cmd_i.res_status;
      out_had_q    <= match_q;
      out_key_q    <= match_q ? KeyW'(old_key_q) : '0;
      out_val_q    <= match_q ? ValueW'(old_val_q) : '0;
      out_total_q  <= TotalW'(count_q);
    end
  end

  assign sts_o.probe_done = hit_empty || hit_match || (rvalid_q && ecnt_last);
  assign sts_o.sweep_last = ecnt_last;
  assign sts_o.match      = match_q;
  assign sts_o.free_found = free_q;
  assign sts_o.can_add    = CmpW'(count_q) < CmpW'(limit_q);
  assign sts_o.out_free   = !out_valid_q || out_ready_i;
  assign sts_o.kind       = kind_q;

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_had_o    = out_had_q;
  assign out_key_o    = out_key_q;
  assign out_value_o  = out_val_q;
  assign out_total_o  = out_total_q;

endmodule

FILE: rtl/linear_probe_hash_map.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear probe hash map
// Open-addressing key/value table with linear probing and tombstones.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake                    payload
//  -------   ---  ---------------------------  ----------------------------------
//  s_axis    in   s_axis_tvalid/s_axis_tready  tuser: kind; tdata: key,hash,value
//  m_axis    out  m_axis_tvalid/m_axis_tready  tuser: status,had; tdata: pair,total
//  cfg       in   cfg_valid_i/cfg_ready_o      fill_limit
//
//  Flow: lookup/insert/remove probe L slots; an insert that moves a pair onto
//  an earlier tombstone also passes through S_TOMB. One slot is read per
//  cycle through the single read port of the slot memory; that port sets the
//  probe speed. Clear writes every slot empty.
//  Reset: after rst_ni rises, a sweep empties the slot memory; s_axis_tready
//  stays low until it ends. Config is taken as ever.
//  Stalls: a result waits in the output register; the next item is accepted
//  meanwhile and only its own result waits for the register to free up.
//  CAPACITY must be a power of two: the home slot is the low hash bits.
// ----------------------------------------------------------------------------
module linear_probe_hash_map #(
  parameter int unsigned CAPACITY  = lphm_pkg::CapacityDef,
  parameter int unsigned KEY_BITS  = lphm_pkg::KeyBitsDef,
  parameter int unsigned DATA_BITS = lphm_pkg::DataBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [95:0]                  s_axis_tdata,   // key, hash_code, new_value
  input  logic [1:0]                   s_axis_tuser,   // kind
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [79:0]                  m_axis_tdata,   // old_key, old_value, entry_total, pad
  output logic [2:0]                   m_axis_tuser,   // status, had_entry
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [lphm_pkg::LimitW-1:0]  cfg_data_i      // fill_limit
);
  import lphm_pkg::*;

  cmd_t                cmd;
  sts_t                sts;
  kind_e               in_kind;
  res_e                out_status;
  logic                out_had;
  logic [KeyW-1:0]     out_key;
  logic [ValueW-1:0]   out_value;
  logic [TotalW-1:0]   out_total;

  // Unpack the input item
  assign in_kind = kind_e'(s_axis_tuser);

  lphm_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_kind_i  (in_kind),
    .sts_i     (sts),
    .s_ready_o (s_axis_tready),
    .cmd_o     (cmd)
  );

  lphm_dp #(
    .CAPACITY  (CAPACITY),
    .KEY_BITS  (KEY_BITS),
    .DATA_BITS (DATA_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_data_i   (cfg_data_i),
    .in_kind_i    (in_kind),
    .in_key_i     (s_axis_tdata[31:0]),
    .in_hash_i    (s_axis_tdata[63:32]),
    .in_value_i   (s_axis_tdata[95:64]),
    .cmd_i        (cmd),
    .out_ready_i  (m_axis_tready),
    .sts_o        (sts),
    .out_valid_o  (m_axis_tvalid),
    .out_status_o (out_status),
    .out_had_o    (out_had),
    .out_key_o    (out_key),
    .out_value_o  (out_value),
    .out_total_o  (out_total)
  );

  // Config is to be written only while idle, which the block leaves to the user; always take it
  assign cfg_ready_o = 1'b1;

  // Pack the result item
  assign m_axis_tdata = {5'b0, out_total, out_value, out_key};
  assign m_axis_tuser = {out_had, out_status};

  // An accepted item keeps the input closed for at least the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted again right after an item");

  // A result is only loaded when the output register can take it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.res_load |-> sts.out_free)
    else $error("result loaded over a pending result");

  // Probe reads and slot writes never share a cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.issue |-> (cmd.wr == WR_NONE) && !cmd.sweep)
    else $error("slot write during probe");

  // A result appears only after the controller loaded one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(cmd.res_load))
    else $error("result shown without a load");

endmodule

FILE: tb/sv/linear_probe_hash_map_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear probe hash map testbench
// Drives lookup, insert, remove and clear items into the hash map. A shadow
// table in the bench predicts each response, and every response is checked
// field by field against it. Both stream sides idle at random. One long
// output stall fills the block, and a full table forces full-pass probes.
// ----------------------------------------------------------------------------
module linear_probe_hash_map_test;
  import lphm_pkg::*;

  localparam int Cap = CapacityDef;

  // Expected response of one item
  typedef struct packed {
    res_e              status;
    logic              had;
    logic [KeyW-1:0]   okey;
    logic [ValueW-1:0] oval;
    logic [TotalW-1:0] total;
  } resp_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [95:0]         s_axis_tdata  = '0;    // key, hash_code, new_value
  logic [1:0]          s_axis_tuser  = '0;    // kind
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [79:0]         m_axis_tdata;          // old_key, old_value, entry_total, pad
  logic [2:0]          m_axis_tuser;          // status, had_entry
  logic                cfg_valid_i   = 1'b0;
  logic                cfg_ready_o;
  logic [LimitW-1:0]   cfg_data_i    = '0;    // fill_limit

  // Shadow copy of the table
  slot_e             shadow_state [Cap];
  logic [KeyW-1:0]   shadow_key   [Cap];
  logic [ValueW-1:0] shadow_val   [Cap];
  int                shadow_live;
  logic [LimitW-1:0] shadow_limit;

  resp_t             pending_resp [$];
  logic [KeyW-1:0]   pool_key     [$];
  logic [HashW-1:0]  pool_hash    [$];
  int                errors      = 0;
  bit                tx_bursty   = 1'b0;
  bit                rx_bursty   = 1'b0;
  int                hold_cycles = 0;

  linear_probe_hash_map dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  // Walk the probe path from the home slot: first live match, first free slot
  function automatic void find_slot(input logic [KeyW-1:0] key, input logic [HashW-1:0] hash,
                                    output int hit, output int spot);
    int pos;
    pos  = hash % Cap;
    hit  = -1;
    spot = -1;
    for (int n = 0; n < Cap; n++) begin
      if (shadow_state[pos] == SLOT_EMPTY) begin
        if (spot < 0) spot = pos;
        return;
      end
      if (shadow_state[pos] == SLOT_LIVE) begin
        if (shadow_key[pos] == key) begin
          hit = pos;
          return;
        end
      end else if (spot < 0) begin
        spot = pos;
      end
      pos = (pos + 1) % Cap;
    end
  endfunction

  // Apply one item to the shadow table and return the response it must cause
  function automatic resp_t map_access(kind_e op, logic [KeyW-1:0] key,
                                       logic [HashW-1:0] hash, logic [ValueW-1:0] val);
    resp_t r;
    int    hit;
    int    spot;
    r = '0;
    r.status = RES_DONE;
    if (op == KIND_CLEAR) begin
      foreach (shadow_state[i]) shadow_state[i] = SLOT_EMPTY;
      shadow_live = 0;
    end else begin
      find_slot(key, hash, hit, spot);
      if (op == KIND_LOOKUP || op == KIND_REMOVE) begin
        if (hit < 0) begin
          r.status = RES_NOT_FOUND;
        end else begin
          r.had  = 1'b1;
          r.okey = shadow_key[hit];
          r.oval = shadow_val[hit];
          if (op == KIND_REMOVE) begin
            shadow_state[hit] = SLOT_TOMB;
            shadow_live--;
          end
        end
      end else if (hit >= 0) begin
        // Replace: move onto an earlier tombstone if the path had one
        r.had  = 1'b1;
        r.okey = shadow_key[hit];
        r.oval = shadow_val[hit];
        if (spot >= 0) begin
          shadow_state[hit] = SLOT_TOMB;
          hit = spot;
        end
        shadow_state[hit] = SLOT_LIVE;
        shadow_key[hit]   = key;
        shadow_val[hit]   = val;
      end else if (shadow_live >= shadow_limit || spot < 0) begin
        r.status = RES_FULL;
      end else begin
        shadow_state[spot] = SLOT_LIVE;
        shadow_key[spot]   = key;
        shadow_val[spot]   = val;
        shadow_live++;
      end
    end
    r.total = shadow_live[TotalW-1:0];
    return r;
  endfunction

  // Offer one item, hold it until accepted, then queue its response
  task automatic send_op(kind_e op, logic [KeyW-1:0] key, logic [HashW-1:0] hash,
                         logic [ValueW-1:0] val);
    int gap;
    if (tx_bursty && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 12);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {val, hash, key};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_resp.push_back(map_access(op, key, hash, val));
  endtask

  // Drop valid and wait until every queued response has come back
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_resp.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_fill_limit(logic [LimitW-1:0] limit);
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= limit;
    do @(posedge clk_i); while (!cfg_ready_o);
    shadow_limit = limit;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Receiver: a long hold when requested, else random stall bursts
  initial begin
    int n;
    @(posedge clk_i);
    forever begin
      if (hold_cycles != 0) begin
        n = hold_cycles;
        hold_cycles = 0;
        m_axis_tready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end else if (rx_bursty && $urandom_range(0, 9) == 0) begin
        n = $urandom_range(1, 12);
        m_axis_tready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
    end
  end

  // Response checker: compare each accepted response with the oldest prediction
  always @(posedge clk_i) begin
    resp_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      if (pending_resp.size() == 0) begin
        errors++;
        $display("%0t: unexpected response, expected none, actual tuser %h tdata %h",
                 $time, m_axis_tuser, m_axis_tdata);
      end else begin
        want = pending_resp.pop_front();
        if (m_axis_tuser[1:0] !== want.status) begin
          errors++;
          $display("%0t: status mismatch, expected %0d, actual %0d",
                   $time, want.status, m_axis_tuser[1:0]);
        end
        if (m_axis_tuser[2] !== want.had) begin
          errors++;
          $display("%0t: had_entry mismatch, expected %0d, actual %0d",
                   $time, want.had, m_axis_tuser[2]);
        end
        if (m_axis_tdata[31:0] !== want.okey) begin
          errors++;
          $display("%0t: old_key mismatch, expected %h, actual %h",
                   $time, want.okey, m_axis_tdata[31:0]);
        end
        if (m_axis_tdata[63:32] !== want.oval) begin
          errors++;
          $display("%0t: old_value mismatch, expected %h, actual %h",
                   $time, want.oval, m_axis_tdata[63:32]);
        end
        if (m_axis_tdata[74:64] !== want.total) begin
          errors++;
          $display("%0t: entry_total mismatch, expected %0d, actual %0d",
                   $time, want.total, m_axis_tdata[74:64]);
        end
      end
    end
  end

  // Misses on an empty table, extreme fields, wrap-around, replace in place,
  // replace onto an earlier tombstone, clear
  task automatic test_basic_ops();
    send_op(KIND_LOOKUP, 32'h0, 32'h0, 32'h0);
    send_op(KIND_REMOVE, 32'h0, 32'h0, 32'h0);
    send_op(KIND_INSERT, 32'h0, 32'h0, 32'h0);
    send_op(KIND_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // Home slot is the last one: wraps past slot 0 into slot 1
    send_op(KIND_INSERT, 32'hA5A5_A5A5, 32'h0000_03FF, 32'h1234_5678);
    send_op(KIND_LOOKUP, 32'hA5A5_A5A5, 32'h0000_03FF, 32'h0);
    send_op(KIND_INSERT, 32'hA5A5_A5A5, 32'h0000_03FF, 32'h0000_DEAD);
    send_op(KIND_REMOVE, 32'h0, 32'h0, 32'h0);
    // Slot 0 is now a tombstone ahead of the match: the pair moves there
    send_op(KIND_INSERT, 32'hA5A5_A5A5, 32'h0000_03FF, 32'h5A5A_5A5A);
    send_op(KIND_LOOKUP, 32'hA5A5_A5A5, 32'h0000_03FF, 32'h0);
    send_op(KIND_LOOKUP, 32'h0, 32'h0, 32'h0);
    send_op(KIND_REMOVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
    send_op(KIND_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_op(KIND_LOOKUP, 32'hA5A5_A5A5, 32'h0000_03FF, 32'h0);
  endtask

  // Refuse new keys at the limit, still allow replacing; limit of zero
  task automatic test_fill_limit();
    write_fill_limit(11'd1);
    send_op(KIND_INSERT, 32'h1111_0001, 32'h0000_0010, 32'hCAFE_0001);
    send_op(KIND_INSERT, 32'h2222_0002, 32'h0000_0010, 32'hCAFE_0002);
    send_op(KIND_INSERT, 32'h1111_0001, 32'h0000_0010, 32'hCAFE_0003);
    write_fill_limit(11'd0);
    send_op(KIND_INSERT, 32'h2222_0002, 32'h0000_0020, 32'hCAFE_0004);
    send_op(KIND_LOOKUP, 32'h1111_0001, 32'h0000_0010, 32'h0);
    send_op(KIND_CLEAR, 32'h0, 32'h0, 32'h0);
  endtask

  // Fill every slot with the limit above capacity; probes then run a full pass
  task automatic test_full_table();
    logic [KeyW-1:0] fkey [Cap];
    logic [31:0]     rnd;
    write_fill_limit(11'd2047);
    for (int i = 0; i < Cap; i++) begin
      rnd = $urandom;
      fkey[i] = {1'b0, rnd[20:0], i[9:0]};
      send_op(KIND_INSERT, fkey[i], {rnd[31:10], i[9:0]}, $urandom);
    end
    // No filled key has the top bit set, so these two keys are absent
    send_op(KIND_INSERT, 32'h8000_0000 | $urandom, $urandom, $urandom);
    send_op(KIND_LOOKUP, 32'h8000_0000 | $urandom, $urandom, 32'h0);
    send_op(KIND_INSERT, fkey[5], 32'h0000_0005, $urandom);
    send_op(KIND_REMOVE, fkey[9], 32'h0000_0009, 32'h0);
    send_op(KIND_INSERT, 32'h8000_1234, 32'h0000_0003, $urandom);
    send_op(KIND_CLEAR, 32'h0, 32'h0, 32'h0);
  endtask

  // Hold the receiver off for a long stretch while items keep coming
  task automatic test_backpressure();
    write_fill_limit(11'd768);
    hold_cycles = 400;
    for (int i = 0; i < 30; i++)
      send_op(kind_e'($urandom_range(0, 2)), $urandom_range(0, 15), $urandom_range(0, 7),
              $urandom);
    send_op(KIND_CLEAR, 32'h0, 32'h0, 32'h0);
  endtask

  // One item from the current key pool, with some stray keys and wrong hashes
  task automatic random_op();
    int               idx;
    int               r;
    int               s;
    kind_e            op;
    logic [KeyW-1:0]  key;
    logic [HashW-1:0] hash;
    idx  = $urandom_range(0, pool_key.size() - 1);
    key  = pool_key[idx];
    hash = pool_hash[idx];
    r    = $urandom_range(0, 99);
    if (r < 4) begin
      key  = $urandom;
      hash = $urandom;
    end else if (r < 8) begin
      hash = $urandom;
    end
    s = $urandom_range(0, 999);
    if (s < 5)        op = KIND_CLEAR;
    else if (s < 480) op = KIND_INSERT;
    else if (s < 780) op = KIND_LOOKUP;
    else              op = KIND_REMOVE;
    send_op(op, key, hash, $urandom);
  endtask

  // Phases with their own limit, key pool and clustering; the last has no idling
  task automatic test_random_traffic();
    int          npool;
    int          spread;
    int          base;
    logic [31:0] rnd;
    for (int phase = 0; phase < 10; phase++) begin
      case (phase % 5)
        0:       write_fill_limit(LimitW'($urandom_range(1, 16)));
        1:       write_fill_limit(LimitW'($urandom_range(17, 400)));
        2:       write_fill_limit(11'd1024);
        3:       write_fill_limit(11'd768);
        default: write_fill_limit(LimitW'($urandom_range(1, 2047)));
      endcase
      tx_bursty = (phase != 9) && (phase % 3 != 1);
      rx_bursty = (phase != 9) && (phase % 3 != 2);
      npool  = $urandom_range(4, 250);
      spread = ($urandom_range(0, 3) == 0) ? Cap - 1 : $urandom_range(0, 63);
      base   = $urandom_range(0, Cap - 1);
      pool_key.delete();
      pool_hash.delete();
      for (int i = 0; i < npool; i++) begin
        rnd = $urandom;
        pool_key.push_back($urandom);
        pool_hash.push_back({rnd[31:10], 10'((base + $urandom_range(0, spread)) % Cap)});
      end
      send_op(KIND_CLEAR, $urandom, $urandom, $urandom);
      repeat (80) random_op();
    end
  endtask

  initial begin
    foreach (shadow_state[i]) shadow_state[i] = SLOT_EMPTY;
    shadow_live  = 0;
    shadow_limit = FillLimitRst;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    tx_bursty = 1'b1;
    rx_bursty = 1'b1;
    test_basic_ops();
    test_fill_limit();
    test_full_table();
    test_backpressure();
    test_random_traffic();
    wait_idle();
    // Catch any stray response after the last one
    repeat (Cap + 8) @(posedge clk_i);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #250_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

FILE: linear_probe_hash_map.f
rtl/lphm_pkg.sv
rtl/lphm_ctrl.sv
rtl/lphm_dp.sv
rtl/linear_probe_hash_map.sv
tb/sv/linear_probe_hash_map_test.sv
